>>> sv/okvt_pkg.sv
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared types and constants for the ordered key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package okvt_pkg;

  localparam int unsigned DefTableDepth = 16;
  localparam int unsigned DefKeyWidth   = 32;
  localparam int unsigned DefValueWidth = 32;
  localparam int unsigned FifoDepth     = 2;

  typedef enum logic [2:0] {
    ACT_CLEAR  = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_STORE  = 3'd2,
    ACT_LOOKUP = 3'd3,
    ACT_FIRST  = 3'd4,
    ACT_NEXT   = 3'd5,
    ACT_RSV6   = 3'd6,
    ACT_RSV7   = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2,
    ST_DONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] key_in;
    logic [31:0] value_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] key_out;
    logic [31:0] value_out;
  } out_item_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    action_t     act;
    logic [63:0] key;
    logic [63:0] value;
  } cmd_t;

endpackage : okvt_pkg

`default_nettype wire

>>> sv/okvt_front.sv
// ----------------------------------------------------------------------------
// okvt_front
// Accepts input transactions, masks fields to the configured widths and
// queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_front #(
  parameter int unsigned KEY_WIDTH   = okvt_pkg::DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = okvt_pkg::DefValueWidth
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire okvt_pkg::in_item_t in_data,
  output logic                   cmd_valid,
  input  wire logic              cmd_take,
  output okvt_pkg::cmd_t         cmd_data
);
  import okvt_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  cmd_t            q_r [FifoDepth];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [PtrW:0]   cnt_r;
  logic            push, pop;
  cmd_t            cmd_in;

  // Classify and mask
  always_comb begin
    cmd_in       = '0;
    cmd_in.act   = action_t'(in_data.action);
    cmd_in.key   = 64'(in_data.key_in)   & ({64{1'b1}} >> (64 - KEY_WIDTH));
    cmd_in.value = 64'(in_data.value_in) & ({64{1'b1}} >> (64 - VALUE_WIDTH));
  end

  assign in_stall  = (cnt_r == (PtrW+1)'(FifoDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd_data  = q_r[rd_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cmd_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PtrW+1)'(FifoDepth)) else $error("queue overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("pop from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("count slip");

endmodule : okvt_front

`default_nettype wire

>>> sv/okvt_back.sv
// ----------------------------------------------------------------------------
// okvt_back
// Cell array with parallel key compare, shift-down removal and the cursor.
// Each command is fetched, then compared and updated, then held as the response.
// ----------------------------------------------------------------------------
`default_nettype none

module okvt_back #(
  parameter int unsigned TABLE_DEPTH = okvt_pkg::DefTableDepth,
  parameter int unsigned KEY_WIDTH   = okvt_pkg::DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = okvt_pkg::DefValueWidth
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_take,
  input  wire okvt_pkg::cmd_t  cmd_data,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output okvt_pkg::out_item_t  out_data
);
  import okvt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_t;

  state_t                 state_r;
  cmd_t                   cmd_r;
  logic [KEY_WIDTH-1:0]   key_r [TABLE_DEPTH];
  logic [VALUE_WIDTH-1:0] val_r [TABLE_DEPTH];
  logic [CntW-1:0]        count_r;
  logic [IdxW-1:0]        cur_r;
  logic                   live_r;
  out_item_t              out_r;
  out_item_t              out_nxt;

  logic [TABLE_DEPTH-1:0] match;
  logic                   any_hit;
  logic [IdxW-1:0]        hit_idx;
  logic [IdxW-1:0]        walk_idx;
  logic                   walk_ok;

  // Parallel compare over live cells, lowest index wins
  always_comb begin
    match   = '0;
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (CntW'(i) < count_r) && (key_r[i] == cmd_r.key[KEY_WIDTH-1:0]);
    end
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hit_idx = IdxW'(i);
      end
    end
  end

  // Cursor entry for first/next
  assign walk_idx = (cmd_r.act == ACT_FIRST) ? '0 : cur_r;
  assign walk_ok  = (cmd_r.act == ACT_FIRST) ? (count_r != '0)
                  : (live_r && CntW'(cur_r) < count_r);

  // Response for the command in execution
  always_comb begin
    out_nxt = '0;
    unique case (cmd_r.act)
      ACT_REMOVE: begin
        if (!any_hit) out_nxt.status = ST_MISS;
      end
      ACT_STORE: begin
        if (!any_hit && count_r >= CntW'(TABLE_DEPTH)) out_nxt.status = ST_FULL;
      end
      ACT_LOOKUP: begin
        if (any_hit) begin
          out_nxt.value_out = 32'(val_r[hit_idx]);
        end else begin
          out_nxt.status = ST_MISS;
        end
      end
      ACT_FIRST, ACT_NEXT: begin
        if (walk_ok) begin
          out_nxt.key_out   = 32'(key_r[walk_idx]);
          out_nxt.value_out = 32'(val_r[walk_idx]);
        end else begin
          out_nxt.status = ST_DONE;
        end
      end
      default: begin
      end
    endcase
  end

  assign cmd_take  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = out_r;

  // Cell array: shift on remove, write on store
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC) begin
      if (cmd_r.act == ACT_REMOVE && any_hit) begin
        for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
          if (IdxW'(i) >= hit_idx) begin
            key_r[i] <= key_r[i+1];
            val_r[i] <= val_r[i+1];
          end
        end
      end else if (cmd_r.act == ACT_STORE) begin
        if (any_hit) begin
          val_r[hit_idx] <= cmd_r.value[VALUE_WIDTH-1:0];
        end else if (count_r < CntW'(TABLE_DEPTH)) begin
          key_r[count_r[IdxW-1:0]] <= cmd_r.key[KEY_WIDTH-1:0];
          val_r[count_r[IdxW-1:0]] <= cmd_r.value[VALUE_WIDTH-1:0];
        end
      end
    end
  end

  // Sequencer, counters, cursor and response register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cur_r   <= '0;
      live_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd_r   <= cmd_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r <= S_OUT;
          out_r   <= out_nxt;
          unique case (cmd_r.act)
            ACT_CLEAR: begin
              count_r <= '0;
              cur_r   <= '0;
              live_r  <= 1'b0;
            end
            ACT_REMOVE: begin
              if (any_hit) begin
                count_r <= count_r - 1'b1;
                if (live_r) begin
                  if (hit_idx < cur_r) begin
                    cur_r <= cur_r - 1'b1;
                  end else if (CntW'(cur_r) >= count_r - 1'b1) begin
                    live_r <= 1'b0;
                  end
                end
              end
            end
            ACT_STORE: begin
              if (!any_hit && count_r < CntW'(TABLE_DEPTH)) begin
                count_r <= count_r + 1'b1;
              end
            end
            ACT_FIRST, ACT_NEXT: begin
              if (walk_ok) begin
                cur_r  <= walk_idx + 1'b1;
                live_r <= (CntW'(walk_idx) + 1'b1) < count_r;
              end else begin
                if (cmd_r.act == ACT_FIRST) cur_r <= '0;
                live_r <= 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(TABLE_DEPTH)) else $error("entry count beyond depth");
  a_live_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    live_r |-> CntW'(cur_r) < count_r) else $error("live cursor past end");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && cmd_r.act == ACT_CLEAR) |=> count_r == '0 && !live_r)
    else $error("clear did not empty table");

endmodule : okvt_back

`default_nettype wire

>>> sv/ordered_key_value_table.sv
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Insertion-ordered associative key/value table with a single cursor.
// ----------------------------------------------------------------------------
//  channel | direction | payload     | handshake
//  in_     | input     | in_item_t   | in_valid / in_stall
//  out_    | output    | out_item_t  | out_valid / out_stall
//
//  In the table engine each transaction is fetched from the queue, then
//  compared and updated across all cells, then held as the response.
//  A two-entry queue lets input be taken while a response waits.
//  Reset (rst_n low, synchronous) empties the table and ends the cursor.
//  A stalled response holds the engine; the queue then fills and stalls input.
`default_nettype none

module ordered_key_value_table #(
  parameter int unsigned TABLE_DEPTH = okvt_pkg::DefTableDepth,
  parameter int unsigned KEY_WIDTH   = okvt_pkg::DefKeyWidth,
  parameter int unsigned VALUE_WIDTH = okvt_pkg::DefValueWidth
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire okvt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output okvt_pkg::out_item_t      out_data
);
  import okvt_pkg::*;

  logic cmd_valid, cmd_take;
  cmd_t cmd_data;

  okvt_front #(.KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd_data
  );

  okvt_back #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH),
              .VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd_data,
    .out_valid, .out_stall, .out_data
  );

endmodule : ordered_key_value_table

`default_nettype wire
